### rtl/core/lpfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label print frame builder package
// Shared constants, register indexes and the types passed between the parts
// of the frame builder.
// ----------------------------------------------------------------------------
package lpfb_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned HDR_LEN     = 17;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [POS_W-1:0] POS_HDR_FIRST = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PAYLOAD   = POS_W'(HDR_LEN);
    localparam logic [POS_W-1:0] POS_CHECKSUM  = POS_W'(HDR_LEN + 1);

    localparam logic [15:0] LEN_OVERHEAD = 16'(HDR_LEN + 1);

    localparam logic [7:0] HDR_MAGIC = 8'h66;
    localparam logic [7:0] HDR_FIXED = 8'h01;
    localparam logic [7:0] HDR_PAD   = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_DARKNESS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_TYPE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAVE_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COPIES_TOTAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_CURRENT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_CODE = 3'd7;

    typedef struct packed {
        logic [4:0]  darkness;
        logic [7:0]  label_type_bits;
        logic [2:0]  cut_mode;
        logic [1:0]  save_mode;
        logic [15:0] copies_total;
        logic [15:0] copy_current;
        logic [15:0] label_width;
        logic [7:0]  command_code;
    } lpfb_cfg_t;

    localparam lpfb_cfg_t CFG_RESET = '{
        darkness:        5'd0,
        label_type_bits: 8'd0,
        cut_mode:        3'd0,
        save_mode:       2'd0,
        copies_total:    16'd1,
        copy_current:    16'd1,
        label_width:     16'd0,
        command_code:    8'd0
    };

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic        first_byte;
        logic [15:0] payload_length;
        logic [15:0] chunk_rows;
        logic [7:0]  chunks_remaining;
    } lpfb_entry_t;

endpackage

### rtl/core/lpfb_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label print frame builder channels
// Valid/ready channels for payload input, frame output and register writes.
// ----------------------------------------------------------------------------
interface lpfb_item_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [15:0] payload_length;
    logic [15:0] chunk_rows;
    logic [7:0]  chunks_remaining;

    modport source (output valid, payload_byte, last_byte, payload_length, chunk_rows,
                    chunks_remaining, input ready);
    modport sink (input valid, payload_byte, last_byte, payload_length, chunk_rows,
                  chunks_remaining, output ready);
endinterface

interface lpfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface lpfb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/lpfb_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label print frame builder configuration registers
// Holds the header settings written through the configuration channel.
// ----------------------------------------------------------------------------
module lpfb_cfg_regs
    import lpfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lpfb_cfg_if.sink   cfg,
    output lpfb_cfg_t  settings
);

    lpfb_cfg_t settings_reg;
    lpfb_cfg_t settings_next;

    assign cfg.ready = 1'b1;
    assign settings  = settings_reg;

    always_comb
    begin
        settings_next = settings_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_DARKNESS:     settings_next.darkness        = cfg.data[4:0];
                REG_LABEL_TYPE:   settings_next.label_type_bits = cfg.data[7:0];
                REG_CUT_MODE:     settings_next.cut_mode        = cfg.data[2:0];
                REG_SAVE_MODE:    settings_next.save_mode       = cfg.data[1:0];
                REG_COPIES_TOTAL: settings_next.copies_total    = cfg.data;
                REG_COPY_CURRENT: settings_next.copy_current    = cfg.data;
                REG_LABEL_WIDTH:  settings_next.label_width     = cfg.data;
                REG_COMMAND_CODE: settings_next.command_code    = cfg.data[7:0];
                default:          settings_next = settings_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg <= CFG_RESET;
        end
        else
        begin
            settings_reg <= settings_next;
        end
    end

endmodule

### rtl/core/lpfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label print frame builder front end
// Accepts payload bytes, marks the first byte of each frame and queues them.
// ----------------------------------------------------------------------------
module lpfb_front
    import lpfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lpfb_item_if.sink    item,
    input  logic         queue_full,
    output logic         push,
    output lpfb_entry_t  push_entry
);

    logic inside_frame_reg;
    logic inside_frame_next;

    assign item.ready = !queue_full;
    assign push       = item.valid && !queue_full;

    always_comb
    begin
        push_entry.payload_byte     = item.payload_byte;
        push_entry.last_byte        = item.last_byte;
        push_entry.first_byte       = !inside_frame_reg;
        push_entry.payload_length   = item.payload_length;
        push_entry.chunk_rows       = item.chunk_rows;
        push_entry.chunks_remaining = item.chunks_remaining;
    end

    always_comb
    begin
        inside_frame_next = inside_frame_reg;
        if (push)
        begin
            inside_frame_next = !item.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_frame_reg <= 1'b0;
        end
        else
        begin
            inside_frame_reg <= inside_frame_next;
        end
    end

endmodule

### rtl/core/lpfb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label print frame builder queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module lpfb_queue
    import lpfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  lpfb_entry_t  push_entry,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output lpfb_entry_t  head_entry
);

    lpfb_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;
    logic               do_pop;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("lpfb_queue: push while full");

    // The occupancy never exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("lpfb_queue: count overflow");

endmodule

### rtl/core/lpfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label print frame builder back end
// Expands queued entries into header, payload and checksum, one per ready cycle.
// ----------------------------------------------------------------------------
module lpfb_back
    import lpfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lpfb_cfg_t    settings,
    input  logic         head_valid,
    input  lpfb_entry_t  head_entry,
    output logic         pop,
    lpfb_frame_if.source frame
);

    logic [POS_W-1:0] step_reg;
    logic [POS_W-1:0] step_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             out_end_reg;
    logic             out_end_next;

    logic [POS_W-1:0] pos;
    logic [15:0]      len_field;
    logic [7:0]       hdr [HDR_LEN];
    logic [7:0]       emit_byte;
    logic             emit;
    logic             done;

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_end  = out_end_reg;

    assign emit      = head_valid && (!out_valid_reg || frame.ready);
    assign pos       = head_entry.first_byte ? step_reg : step_reg + POS_PAYLOAD;
    assign len_field = head_entry.payload_length + LEN_OVERHEAD;
    assign done      = (pos == POS_CHECKSUM) || ((pos == POS_PAYLOAD) && !head_entry.last_byte);
    assign pop       = emit && done;

    always_comb
    begin
        hdr[0]  = HDR_MAGIC;
        hdr[1]  = len_field[7:0];
        hdr[2]  = len_field[15:8];
        hdr[3]  = settings.command_code;
        hdr[4]  = {3'b000, settings.darkness} | settings.label_type_bits;
        hdr[5]  = {3'b000, settings.save_mode, settings.cut_mode};
        hdr[6]  = settings.copies_total[7:0];
        hdr[7]  = settings.copies_total[15:8];
        hdr[8]  = settings.copy_current[7:0];
        hdr[9]  = settings.copy_current[15:8];
        hdr[10] = HDR_FIXED;
        hdr[11] = settings.label_width[7:0];
        hdr[12] = settings.label_width[15:8];
        hdr[13] = head_entry.chunk_rows[7:0];
        hdr[14] = head_entry.chunk_rows[15:8];
        hdr[15] = head_entry.chunks_remaining;
        hdr[16] = HDR_PAD;
    end

    always_comb
    begin
        if (pos == POS_CHECKSUM)
        begin
            emit_byte = 8'd0 - sum_reg;
        end
        else if (pos == POS_PAYLOAD)
        begin
            emit_byte = head_entry.payload_byte;
        end
        else
        begin
            emit_byte = hdr[pos];
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        if (out_valid_reg && frame.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_end_next   = (pos == POS_CHECKSUM);
            step_next      = done ? '0 : step_reg + 1'b1;
            if (pos == POS_HDR_FIRST)
            begin
                sum_next = emit_byte;
            end
            else if (pos == POS_CHECKSUM)
            begin
                sum_next = 8'd0;
            end
            else
            begin
                sum_next = sum_reg + emit_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

    // The byte counter never runs past the checksum position.
    assert property (@(posedge clk) disable iff (!rst_n) step_reg <= POS_CHECKSUM)
        else $error("lpfb_back: step counter out of range");

    // An entry that is partly expanded stays at the head of the queue.
    assert property (@(posedge clk) disable iff (!rst_n) (step_reg != '0) |-> head_valid)
        else $error("lpfb_back: head lost mid-expansion");

    // Without an emitted byte the expansion does not advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!emit) |=> $stable(step_reg))
        else $error("lpfb_back: step moved without a transfer");

endmodule

### rtl/core/label_print_frame_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label print frame builder
// Wraps a byte-wide printer payload in a print-data frame with header and
// checksum.
// ----------------------------------------------------------------------------
// Frame bytes go out one per cycle while the sink is ready. The first payload
// byte of a frame produces 18 output bytes (the 17-byte header and the byte
// itself, 19 if it is also the last), a middle byte produces one and the last
// byte two (the byte and the checksum). Input bytes are accepted every cycle
// while the four-entry queue between the front end and the byte sequencer has
// room. A frame of N payload bytes becomes N + 18 output bytes. Register
// writes take effect on the next cycle and shape headers built after them.
module label_print_frame_builder_unit
    import lpfb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lpfb_item_if.sink     item,
    lpfb_frame_if.source  frame,
    lpfb_cfg_if.sink      cfg
);

    lpfb_cfg_t    settings;
    logic         queue_full;
    logic         push;
    lpfb_entry_t  push_entry;
    logic         pop;
    logic         head_valid;
    lpfb_entry_t  head_entry;

    lpfb_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    lpfb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    lpfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    lpfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .settings   (settings),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .frame      (frame)
    );

endmodule

### sim/label_print_frame_builder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label print frame builder testbench
// Streams payload frames into the builder under random source gaps and sink
// stalls. A scoreboard builds the expected header, payload and checksum bytes
// for every accepted input transfer and compares them with each output
// transfer. Register settings change between frames: reset values, all ones,
// all zeros and random values.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
} frame_beat_t;

class frame_scoreboard;
    lpfb_pkg::lpfb_cfg_t regs;
    bit                  in_frame;
    logic [7:0]          running_sum;
    frame_beat_t         pending[$];
    int unsigned         mismatches;

    function new();
        regs.darkness        = '0;
        regs.label_type_bits = '0;
        regs.cut_mode        = '0;
        regs.save_mode       = '0;
        regs.copies_total    = 16'd1;
        regs.copy_current    = 16'd1;
        regs.label_width     = '0;
        regs.command_code    = '0;
        in_frame             = 1'b0;
        running_sum          = '0;
        mismatches           = 0;
    endfunction

    function void apply_write(logic [2:0] idx, logic [15:0] data);
        case (idx)
            lpfb_pkg::REG_DARKNESS:     regs.darkness        = data[4:0];
            lpfb_pkg::REG_LABEL_TYPE:   regs.label_type_bits = data[7:0];
            lpfb_pkg::REG_CUT_MODE:     regs.cut_mode        = data[2:0];
            lpfb_pkg::REG_SAVE_MODE:    regs.save_mode       = data[1:0];
            lpfb_pkg::REG_COPIES_TOTAL: regs.copies_total    = data;
            lpfb_pkg::REG_COPY_CURRENT: regs.copy_current    = data;
            lpfb_pkg::REG_LABEL_WIDTH:  regs.label_width     = data;
            lpfb_pkg::REG_COMMAND_CODE: regs.command_code    = data[7:0];
            default: ;
        endcase
    endfunction

    function void push_byte(logic [7:0] value, logic is_end);
        frame_beat_t beat;
        beat.frame_byte = value;
        beat.frame_end  = is_end;
        pending.insert(pending.size(), beat);
        running_sum = running_sum + value;
    endfunction

    // Works out every frame byte that one accepted payload transfer causes.
    function void note_payload(logic [7:0] pb, logic last, logic [15:0] plen,
                               logic [15:0] rows, logic [7:0] chunks);
        logic [15:0] length_field;
        if (!in_frame) begin
            length_field = plen + lpfb_pkg::LEN_OVERHEAD;
            running_sum  = '0;
            push_byte(lpfb_pkg::HDR_MAGIC, 1'b0);
            push_byte(length_field[7:0], 1'b0);
            push_byte(length_field[15:8], 1'b0);
            push_byte(regs.command_code, 1'b0);
            push_byte({3'b000, regs.darkness} | regs.label_type_bits, 1'b0);
            push_byte({3'b000, regs.save_mode, regs.cut_mode}, 1'b0);
            push_byte(regs.copies_total[7:0], 1'b0);
            push_byte(regs.copies_total[15:8], 1'b0);
            push_byte(regs.copy_current[7:0], 1'b0);
            push_byte(regs.copy_current[15:8], 1'b0);
            push_byte(lpfb_pkg::HDR_FIXED, 1'b0);
            push_byte(regs.label_width[7:0], 1'b0);
            push_byte(regs.label_width[15:8], 1'b0);
            push_byte(rows[7:0], 1'b0);
            push_byte(rows[15:8], 1'b0);
            push_byte(chunks, 1'b0);
            push_byte(lpfb_pkg::HDR_PAD, 1'b0);
            in_frame = 1'b1;
        end
        push_byte(pb, 1'b0);
        if (last) begin
            push_byte(8'h00 - running_sum, 1'b1);
            in_frame    = 1'b0;
            running_sum = '0;
        end
    endfunction

    function void check_frame_byte(logic [7:0] actual_byte, logic actual_end);
        frame_beat_t want;
        if (pending.size() == 0) begin
            $error("unexpected transfer: frame_byte %h frame_end %b", actual_byte, actual_end);
            mismatches++;
        end else begin
            want = pending.pop_front();
            if (actual_byte !== want.frame_byte) begin
                $error("frame_byte: expected %h, actual %h", want.frame_byte, actual_byte);
                mismatches++;
            end
            if (actual_end !== want.frame_end) begin
                $error("frame_end: expected %b, actual %b", want.frame_end, actual_end);
                mismatches++;
            end
        end
    endfunction
endclass

module label_print_frame_builder_unit_tb;
    import lpfb_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASES        = 6;
    localparam int unsigned PHASE_ITEMS   = 52;
    localparam int unsigned TAIL_CYCLES   = 40;

    logic clk;
    logic rst_n;

    lpfb_item_if  item_if();
    lpfb_frame_if frame_if();
    lpfb_cfg_if   cfg_if();

    frame_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int          burst_left;

    label_print_frame_builder_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .frame (frame_if),
        .cfg   (cfg_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.apply_write(cfg_if.index, cfg_if.data);
            if (item_if.valid && item_if.ready)
                sb.note_payload(item_if.payload_byte, item_if.last_byte,
                                item_if.payload_length, item_if.chunk_rows,
                                item_if.chunks_remaining);
            if (frame_if.valid && frame_if.ready)
                sb.check_frame_byte(frame_if.frame_byte, frame_if.frame_end);
        end
    end

    // The sink alternates between stretches of full rate, random stalls,
    // heavy stalls and a periodic pattern.
    initial begin
        int stall_mode;
        int stall_left;
        frame_if.ready = 1'b0;
        stall_mode     = 0;
        stall_left     = 0;
        forever begin
            @(negedge clk);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_mode)
                0:       frame_if.ready = 1'b1;
                1:       frame_if.ready = 1'($urandom_range(0, 1));
                2:       frame_if.ready = ($urandom_range(0, 3) == 0);
                default: frame_if.ready = (stall_left % 5 != 0);
            endcase
        end
    end

    task automatic send_item(input logic [7:0] pb, input logic last, input logic [15:0] plen,
                             input logic [15:0] rows, input logic [7:0] chunks);
        int gap;
        item_if.valid            = 1'b1;
        item_if.payload_byte     = pb;
        item_if.last_byte        = last;
        item_if.payload_length   = plen;
        item_if.chunk_rows       = rows;
        item_if.chunks_remaining = chunks;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap           = $urandom_range(1, 8);
            item_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_if.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [15:0] pick_setting(int phase);
        int r;
        r = $urandom_range(0, 3);
        if (phase == 1)
            return 16'hFFFF;
        if (phase == 2)
            return 16'h0000;
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    initial begin
        int          phase_items;
        int          frame_len;
        int          sel;
        logic [15:0] plen;
        burst_left               = 0;
        rst_n                    = 1'b0;
        item_if.valid            = 1'b0;
        item_if.payload_byte     = '0;
        item_if.last_byte        = 1'b0;
        item_if.payload_length   = '0;
        item_if.chunk_rows       = '0;
        item_if.chunks_remaining = '0;
        cfg_if.valid             = 1'b0;
        cfg_if.index             = REG_DARKNESS;
        cfg_if.data              = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single-byte frames: zero length, and a length field that wraps.
        send_item(8'h00, 1'b1, 16'd0, 16'h0000, 8'h00);
        send_item(8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
        // A frame whose length field matches its payload.
        send_item(8'h55, 1'b0, 16'd3, 16'h1234, 8'h80);
        send_item(8'hAA, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(8'h01, 1'b1, 16'h0000, 16'h0000, 8'h00);
        // The length field says one byte but the frame carries four.
        send_item(8'h80, 1'b0, 16'd1, 16'hA5C3, 8'h01);
        send_item(8'h7F, 1'b0, 16'd1, 16'h0000, 8'h00);
        send_item(8'hC3, 1'b0, 16'd1, 16'h0000, 8'h00);
        send_item(8'h3C, 1'b1, 16'd1, 16'h0000, 8'h00);
        // Largest length that fits, and the first one that wraps to zero.
        send_item(8'h12, 1'b0, 16'd65517, 16'h8001, 8'h7F);
        send_item(8'hED, 1'b1, 16'd65517, 16'h0000, 8'h00);
        send_item(8'h99, 1'b1, 16'd65518, 16'h00FF, 8'h10);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_drained();
                write_reg(REG_DARKNESS,     pick_setting(phase));
                write_reg(REG_LABEL_TYPE,   pick_setting(phase));
                write_reg(REG_CUT_MODE,     pick_setting(phase));
                write_reg(REG_SAVE_MODE,    pick_setting(phase));
                write_reg(REG_COPIES_TOTAL, pick_setting(phase));
                write_reg(REG_COPY_CURRENT, pick_setting(phase));
                write_reg(REG_LABEL_WIDTH,  pick_setting(phase));
                write_reg(REG_COMMAND_CODE, pick_setting(phase));
                cfg_if.valid = 1'b0;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                frame_len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40)
                                                        : $urandom_range(1, 8);
                sel = $urandom_range(0, 9);
                if (sel <= 5)
                    plen = 16'(frame_len);
                else if (sel == 6)
                    plen = 16'd0;
                else if (sel == 7)
                    plen = 16'hFFFF;
                else if (sel == 8)
                    plen = 16'($urandom);
                else
                    plen = $urandom_range(0, 1) ? 16'd65517 : 16'd65518;
                send_item(8'($urandom), frame_len == 1, plen,
                          16'($urandom), 8'($urandom));
                for (int k = 1; k < frame_len; k++)
                    send_item(8'($urandom), k == frame_len - 1, 16'($urandom),
                              16'($urandom), 8'($urandom));
                phase_items += frame_len;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### label_print_frame_builder_unit.f
rtl/core/lpfb_pkg.sv
rtl/core/lpfb_ifs.sv
rtl/core/lpfb_cfg_regs.sv
rtl/core/lpfb_front.sv
rtl/core/lpfb_queue.sv
rtl/core/lpfb_back.sv
rtl/core/label_print_frame_builder_unit.sv
sim/label_print_frame_builder_unit_tb.sv
